[hw/rtl/thos_pkg.sv]
// ----------------------------------------------------------------------------
// thos_pkg
// types and constants shared by the tcp header option statistics unit
// ----------------------------------------------------------------------------
package thos_pkg;

  localparam int unsigned COUNTER_WIDTH   = 32;
  localparam int unsigned MAX_FRAME_BYTES = 2048;

  localparam int unsigned POS_W    = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned KIND_W   = 8;
  localparam int unsigned NUM_KIND = 1 << KIND_W;
  localparam int unsigned NUM_FLAG = 8;
  localparam int unsigned CMP_W    = 16;

  localparam logic [7:0] ETHERTYPE_HI = 8'h08;
  localparam logic [7:0] ETHERTYPE_LO = 8'h00;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] OPT_END      = 8'h00;
  localparam logic [7:0] OPT_NOP      = 8'h01;
  localparam logic [7:0] OPT_MIN_LEN  = 8'd2;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_RD_FLAG = 2'd1,
    OP_RD_KIND = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PHASE_KIND   = 2'd0,
    PHASE_LENGTH = 2'd1
  } phase_e;

  typedef enum logic {
    RES_SUMMARY = 1'b0,
    RES_COUNTER = 1'b1
  } res_kind_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [7:0] counter_index;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic        frame_is_tcp;
    logic [7:0]  flags_seen;
    logic [4:0]  options_counted;
    logic        options_malformed;
    logic        frame_truncated;
    logic [31:0] counter_value;
  } out_t;

  // transaction waiting for its counter memory access
  typedef struct packed {
    logic              has_result;
    logic              bump;
    logic              ram_rd;
    logic [KIND_W-1:0] addr;
    logic              ent_valid;
    out_t              res;
  } s1_t;

endpackage

[hw/rtl/thos_ram.sv]
// ----------------------------------------------------------------------------
// thos_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module thos_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/tcp_header_option_statistics_unit.sv]
// ----------------------------------------------------------------------------
// tcp_header_option_statistics_unit
// tcp flag and option kind statistics over a byte stream of ethernet frames
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid_i / in_stall_o / in_data_i) carries frame bytes
//   (opcode byte) and counter reads (flag or option kind). a byte with
//   last_byte set closes the frame and yields one summary transaction; each
//   read yields one counter transaction. other bytes yield nothing.
//   out channel (out_valid_o / out_stall_i / out_data_o) returns results.
// timing:
//   one transaction accepted per cycle while in_stall_o is low. the per-frame
//   parse runs in the accept cycle; option kind counters live in a 256 entry
//   ram with a registered read, updated by a read-modify-write in the
//   following stage with forwarding of the last write. a result passes the
//   ram stage register and the output register before it shows on out_valid_o.
// reset:
//   all frame state and counters clear at once; option counter entries
//   read as zero until first written, tracked by one valid bit per entry.
// stall:
//   the output register holds its result while out_stall_i is high; one
//   more result can wait in the ram stage, after which in_stall_o rises.
// ----------------------------------------------------------------------------
module tcp_header_option_statistics_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  thos_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output thos_pkg::out_t out_data_o
);

  localparam int unsigned CW = thos_pkg::COUNTER_WIDTH;
  localparam int unsigned PW = thos_pkg::POS_W;
  localparam int unsigned KW = thos_pkg::KIND_W;
  localparam int unsigned XW = thos_pkg::CMP_W;

  localparam logic [CW-1:0] CNT_MAX = '1;

  // frame parse state
  logic [PW-1:0]    pos_q, pos_d;
  logic             is_ipv4_q, is_ipv4_d;
  logic             is_tcp_q, is_tcp_d;
  logic [3:0]       ip_words_q, ip_words_d;
  logic [3:0]       tcp_words_q, tcp_words_d;
  logic [7:0]       flags_q, flags_d;
  logic [5:0]       nos_q, nos_d;
  thos_pkg::phase_e phase_q, phase_d;
  logic [7:0]       kind_q, kind_d;
  logic             stopped_q, stopped_d;
  logic             malf_q, malf_d;
  logic [4:0]       tally_q, tally_d;

  logic [CW-1:0]    flag_cnt_q [thos_pkg::NUM_FLAG];
  logic [7:0]       flag_inc;

  logic [thos_pkg::NUM_KIND-1:0] opt_valid_q;

  logic            accept, out_ready, s1_leave, ram_we, ram_re;
  logic            s1_valid_q;
  thos_pkg::s1_t   s1_q, s1_d;
  logic            out_valid_q;
  thos_pkg::out_t  out_q, res1;

  logic            fwd_valid_q;
  logic [KW-1:0]   fwd_addr_q;
  logic [CW-1:0]   fwd_data_q;

  logic [CW-1:0]   rdata, cur, inc;
  logic [63:0]     cur_ext, flag_ext;

  logic            is_byte, bump_req;
  logic [7:0]      b;
  logic [XW-1:0]   pos_w, tcp_start, off, area, hdr, need, len_end;

  assign is_byte   = (in_data_i.opcode == thos_pkg::OP_BYTE);
  assign b         = in_data_i.data_byte;
  assign out_ready = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && s1_q.has_result && !out_ready;
  assign accept    = in_valid_i && !in_stall_o;

  assign pos_w     = XW'(pos_q);
  assign tcp_start = XW'(14) + XW'({ip_words_q, 2'b00});
  assign off       = pos_w - (tcp_start + XW'(20));
  assign area      = XW'({tcp_words_q, 2'b00}) - XW'(20);
  assign len_end   = XW'(nos_q) + XW'(b);

  // frame parse, option walk, summary and counter read requests
  always_comb begin
    pos_d       = pos_q;
    is_ipv4_d   = is_ipv4_q;
    is_tcp_d    = is_tcp_q;
    ip_words_d  = ip_words_q;
    tcp_words_d = tcp_words_q;
    flags_d     = flags_q;
    nos_d       = nos_q;
    phase_d     = phase_q;
    kind_d      = kind_q;
    stopped_d   = stopped_q;
    malf_d      = malf_q;
    tally_d     = tally_q;
    flag_inc    = '0;
    bump_req    = 1'b0;
    hdr         = '0;
    need        = '0;
    s1_d        = '0;
    if (accept && is_byte) begin
      if (pos_q < PW'(thos_pkg::MAX_FRAME_BYTES)) begin
        pos_d = pos_q + PW'(1);
        if (pos_w == XW'(12)) begin
          is_ipv4_d = (b == thos_pkg::ETHERTYPE_HI);
        end else if (pos_w == XW'(13)) begin
          is_ipv4_d = is_ipv4_q && (b == thos_pkg::ETHERTYPE_LO);
        end else if (pos_w == XW'(14)) begin
          if (is_ipv4_q) begin
            ip_words_d = b[3:0];
          end
        end else if (pos_w == XW'(23)) begin
          is_tcp_d = is_ipv4_q && (ip_words_q >= 4'd5) && (b == thos_pkg::PROTO_TCP);
        end
        if (is_tcp_d && pos_w >= tcp_start) begin
          if (pos_w == tcp_start + XW'(12)) begin
            tcp_words_d = b[7:4];
          end else if (pos_w == tcp_start + XW'(13)) begin
            flags_d  = b;
            flag_inc = b;
          end else if (pos_w >= tcp_start + XW'(20) && tcp_words_q > 4'd5) begin
            if (!stopped_q && off < area) begin
              case (phase_q)
                thos_pkg::PHASE_KIND: begin
                  if (off == XW'(nos_q)) begin
                    if (b == thos_pkg::OPT_END) begin
                      stopped_d = 1'b1;
                    end else if (b == thos_pkg::OPT_NOP) begin
                      nos_d = 6'(off + XW'(1));
                    end else if (off + XW'(1) >= area) begin
                      // length byte would fall outside the option area
                      stopped_d = 1'b1;
                      malf_d    = 1'b1;
                    end else begin
                      kind_d  = b;
                      phase_d = thos_pkg::PHASE_LENGTH;
                    end
                  end
                end
                thos_pkg::PHASE_LENGTH: begin
                  if (b < thos_pkg::OPT_MIN_LEN || len_end > area) begin
                    stopped_d = 1'b1;
                    malf_d    = 1'b1;
                  end else begin
                    bump_req = 1'b1;
                    tally_d  = tally_q + 5'd1;
                    nos_d    = 6'(len_end);
                    phase_d  = thos_pkg::PHASE_KIND;
                  end
                end
                default: begin
                  phase_d = thos_pkg::PHASE_KIND;
                end
              endcase
            end
          end
        end
      end
      if (in_data_i.last_byte) begin
        hdr  = (tcp_words_d >= 4'd5) ? XW'({tcp_words_d, 2'b00}) : XW'(20);
        need = XW'(14) + XW'({ip_words_d, 2'b00}) + hdr;
        s1_d.has_result      = 1'b1;
        s1_d.res.result_kind = thos_pkg::RES_SUMMARY;
        if (is_tcp_d) begin
          s1_d.res.frame_is_tcp      = 1'b1;
          s1_d.res.flags_seen        = flags_d;
          s1_d.res.options_counted   = tally_d;
          s1_d.res.options_malformed = malf_d;
          s1_d.res.frame_truncated   = (XW'(pos_d) < need);
        end
        pos_d       = '0;
        is_ipv4_d   = 1'b0;
        is_tcp_d    = 1'b0;
        ip_words_d  = '0;
        tcp_words_d = '0;
        flags_d     = '0;
        nos_d       = '0;
        phase_d     = thos_pkg::PHASE_KIND;
        kind_d      = '0;
        stopped_d   = 1'b0;
        malf_d      = 1'b0;
        tally_d     = '0;
      end
    end else if (accept && in_data_i.opcode == thos_pkg::OP_RD_FLAG) begin
      s1_d.has_result          = 1'b1;
      s1_d.res.result_kind     = thos_pkg::RES_COUNTER;
      s1_d.res.counter_value   = flag_ext[31:0];
    end else if (accept && in_data_i.opcode == thos_pkg::OP_RD_KIND) begin
      s1_d.has_result      = 1'b1;
      s1_d.ram_rd          = 1'b1;
      s1_d.res.result_kind = thos_pkg::RES_COUNTER;
    end
    s1_d.bump      = bump_req;
    s1_d.addr      = bump_req ? kind_q : in_data_i.counter_index;
    s1_d.ent_valid = opt_valid_q[s1_d.addr];
  end

  assign flag_ext = (in_data_i.counter_index < 8'(thos_pkg::NUM_FLAG))
                    ? 64'(flag_cnt_q[in_data_i.counter_index[2:0]]) : '0;

  assign ram_re = accept && (s1_d.bump || s1_d.ram_rd);

  thos_ram #(
    .WIDTH (CW),
    .DEPTH (thos_pkg::NUM_KIND)
  ) u_kind_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_q.addr),
    .wdata_i (inc),
    .re_i    (ram_re),
    .raddr_i (s1_d.addr),
    .rdata_o (rdata)
  );

  // counter stage: forward the most recent write, unwritten entries read zero, saturating increment
  always_comb begin
    if (fwd_valid_q && fwd_addr_q == s1_q.addr) begin
      cur = fwd_data_q;
    end else if (s1_q.ent_valid) begin
      cur = rdata;
    end else begin
      cur = '0;
    end
    inc     = (cur == CNT_MAX) ? cur : cur + CW'(1);
    cur_ext = 64'(cur);
    res1    = s1_q.res;
    if (s1_q.ram_rd) begin
      res1.counter_value = cur_ext[31:0];
    end
  end

  assign s1_leave = s1_valid_q && (!s1_q.has_result || out_ready);
  assign ram_we   = s1_leave && s1_q.bump;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      is_ipv4_q   <= 1'b0;
      is_tcp_q    <= 1'b0;
      ip_words_q  <= '0;
      tcp_words_q <= '0;
      flags_q     <= '0;
      nos_q       <= '0;
      phase_q     <= thos_pkg::PHASE_KIND;
      kind_q      <= '0;
      stopped_q   <= 1'b0;
      malf_q      <= 1'b0;
      tally_q     <= '0;
      opt_valid_q <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_valid_q <= 1'b0;
      for (int i = 0; i < thos_pkg::NUM_FLAG; i++) begin
        flag_cnt_q[i] <= '0;
      end
    end else begin
      pos_q       <= pos_d;
      is_ipv4_q   <= is_ipv4_d;
      is_tcp_q    <= is_tcp_d;
      ip_words_q  <= ip_words_d;
      tcp_words_q <= tcp_words_d;
      flags_q     <= flags_d;
      nos_q       <= nos_d;
      phase_q     <= phase_d;
      kind_q      <= kind_d;
      stopped_q   <= stopped_d;
      malf_q      <= malf_d;
      tally_q     <= tally_d;
      for (int i = 0; i < thos_pkg::NUM_FLAG; i++) begin
        if (flag_inc[i] && flag_cnt_q[i] != CNT_MAX) begin
          flag_cnt_q[i] <= flag_cnt_q[i] + CW'(1);
        end
      end
      if (ram_we) begin
        opt_valid_q[s1_q.addr] <= 1'b1;
        fwd_valid_q            <= 1'b1;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_leave) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_leave && s1_q.has_result) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (ram_we) begin
      fwd_addr_q <= s1_q.addr;
      fwd_data_q <= inc;
    end
    if (s1_leave && s1_q.has_result) begin
      out_q <= res1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && s1_valid_q))
    else $error("input stalled without a full output path");

  a_tally_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tally_q <= 5'd20)
    else $error("option tally beyond what the option area can hold");

  a_length_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == thos_pkg::PHASE_LENGTH) |-> (kind_q > thos_pkg::OPT_NOP))
    else $error("awaiting a length for a kind without one");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_byte && in_data_i.last_byte) |=> (pos_q == '0 && tally_q == '0))
    else $error("frame state not cleared after summary");

  a_ram_op_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_q.bump) |-> !s1_q.ram_rd)
    else $error("counter update and counter read in one transaction");

endmodule
